### sv/assert_macros.svh
// Assertion macros used by the parser unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GZHP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define GZHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define GZHP_ASSERT_SAME(lbl, ante, cons, msg)
`define GZHP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### sv/gzhp_pkg.sv
// Types, codes and helper functions of the gzip header parser.
`timescale 1ns / 1ps
package gzhp_pkg;

  localparam logic [3:0] PH_FIXED   = 4'd0;
  localparam logic [3:0] PH_XLEN_LO = 4'd1;
  localparam logic [3:0] PH_XLEN_HI = 4'd2;
  localparam logic [3:0] PH_XDATA   = 4'd3;
  localparam logic [3:0] PH_NAME    = 4'd4;
  localparam logic [3:0] PH_COMMENT = 4'd5;
  localparam logic [3:0] PH_HCRC    = 4'd6;
  localparam logic [3:0] PH_PAYLOAD = 4'd7;
  localparam logic [3:0] PH_ERROR   = 4'd8;

  localparam logic [7:0] FLG_HCRC     = 8'h02;
  localparam logic [7:0] FLG_EXTRA    = 8'h04;
  localparam logic [7:0] FLG_NAME     = 8'h08;
  localparam logic [7:0] FLG_COMMENT  = 8'h10;
  localparam logic [7:0] FLG_RESERVED = 8'hE0;

  localparam logic [7:0] MAGIC_ID1    = 8'h1F;
  localparam logic [7:0] MAGIC_ID2    = 8'h8B;
  localparam logic [7:0] METHOD_DEFL  = 8'h08;
  localparam logic [3:0] FIXED_LAST   = 4'd9;
  localparam logic [3:0] IDX_ID1      = 4'd0;
  localparam logic [3:0] IDX_ID2      = 4'd1;
  localparam logic [3:0] IDX_METHOD   = 4'd2;
  localparam logic [3:0] IDX_FLAGS    = 4'd3;
  localparam logic [15:0] HCRC_LEN    = 16'd2;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_MAGIC     = 3'd1;
  localparam logic [2:0] ERR_METHOD    = 3'd2;
  localparam logic [2:0] ERR_RESERVED  = 3'd3;
  localparam logic [2:0] ERR_TRUNCATED = 3'd4;

  typedef struct packed {
    logic [3:0]  phase;
    logic [3:0]  fixed_index;
    logic [7:0]  flag_bits;
    logic [15:0] skip_remaining;
    logic [7:0]  extra_len_low;
    logic [2:0]  error_held;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase: PH_FIXED, fixed_index: 4'd0, flag_bits: 8'd0,
    skip_remaining: 16'd0, extra_len_low: 8'd0, error_held: ERR_NONE
  };

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] err;
  } beat_class_t;

  // Returns the section that follows the finished section done.
  function automatic logic [3:0] next_section(input logic [3:0] done,
                                              input logic [7:0] flags);
    logic [3:0] ph;
    ph = PH_PAYLOAD;
    if (done < PH_HCRC && (flags & FLG_HCRC) != 8'd0) ph = PH_HCRC;
    if (done < PH_COMMENT && (flags & FLG_COMMENT) != 8'd0) ph = PH_COMMENT;
    if (done < PH_NAME && (flags & FLG_NAME) != 8'd0) ph = PH_NAME;
    if (done < PH_XLEN_LO && (flags & FLG_EXTRA) != 8'd0) ph = PH_XLEN_LO;
    return ph;
  endfunction

endpackage

### sv/gzhp_step.sv
// Next-state and classification logic for one stream byte.
`timescale 1ns / 1ps
module gzhp_step import gzhp_pkg::*; (
  input  parse_state_t cur,
  input  logic [7:0]   in_byte,
  input  logic         end_of_data,
  input  logic         stream_start,
  output parse_state_t nxt,
  output beat_class_t  cls
);

  parse_state_t st;
  parse_state_t wrk;
  logic [2:0]   err;
  logic [1:0]   kind;
  logic [15:0]  skip_dec;
  logic [15:0]  xlen;

  always_comb begin
    st = stream_start ? STATE_RESET : cur;
    wrk = st;
    err = ERR_NONE;
    kind = KIND_HEADER;
    skip_dec = st.skip_remaining - 16'd1;
    xlen = {in_byte, st.extra_len_low};

    if (st.phase == PH_ERROR) begin
      kind = KIND_ERROR;
      err = st.error_held;
    end else if (st.phase == PH_PAYLOAD) begin
      kind = KIND_PAYLOAD;
    end else begin
      case (st.phase)
        PH_FIXED: begin
          if (st.fixed_index == IDX_ID1 && in_byte != MAGIC_ID1) begin
            err = ERR_MAGIC;
          end else if (st.fixed_index == IDX_ID2 && in_byte != MAGIC_ID2) begin
            err = ERR_MAGIC;
          end else if (st.fixed_index == IDX_METHOD && in_byte != METHOD_DEFL) begin
            err = ERR_METHOD;
          end else if (st.fixed_index == IDX_FLAGS) begin
            if ((in_byte & FLG_RESERVED) != 8'd0) begin
              err = ERR_RESERVED;
            end else begin
              wrk.flag_bits = in_byte;
            end
          end
          if (err == ERR_NONE) begin
            if (st.fixed_index >= FIXED_LAST) begin
              wrk.fixed_index = 4'd0;
              wrk.phase = next_section(PH_FIXED, wrk.flag_bits);
            end else begin
              wrk.fixed_index = st.fixed_index + 4'd1;
            end
          end
        end
        PH_XLEN_LO: begin
          wrk.extra_len_low = in_byte;
          wrk.phase = PH_XLEN_HI;
        end
        PH_XLEN_HI: begin
          wrk.skip_remaining = xlen;
          wrk.phase = (xlen == 16'd0) ? next_section(PH_XDATA, st.flag_bits) : PH_XDATA;
        end
        PH_XDATA: begin
          wrk.skip_remaining = skip_dec;
          if (skip_dec == 16'd0) begin
            wrk.phase = next_section(PH_XDATA, st.flag_bits);
          end
        end
        PH_NAME: begin
          if (in_byte == 8'd0) begin
            wrk.phase = next_section(PH_NAME, st.flag_bits);
          end
        end
        PH_COMMENT: begin
          if (in_byte == 8'd0) begin
            wrk.phase = next_section(PH_COMMENT, st.flag_bits);
          end
        end
        PH_HCRC: begin
          wrk.skip_remaining = skip_dec;
          if (skip_dec == 16'd0) begin
            wrk.phase = PH_PAYLOAD;
          end
        end
        default: begin
          err = st.error_held;
        end
      endcase
      // Entering the CRC section loads its two-byte count.
      if (wrk.phase == PH_HCRC && st.phase != PH_HCRC) begin
        wrk.skip_remaining = HCRC_LEN;
      end
      if (err == ERR_NONE && end_of_data && wrk.phase != PH_PAYLOAD) begin
        err = ERR_TRUNCATED;
      end
      if (err != ERR_NONE) begin
        kind = KIND_ERROR;
        wrk.error_held = err;
        wrk.phase = PH_ERROR;
      end
    end

    nxt = wrk;
    cls.kind = kind;
    cls.err = (kind == KIND_ERROR) ? err : ERR_NONE;
  end

endmodule

### sv/gzip_header_parser_unit.sv
// gzip member header parser: top level with input and result registers.
//
// The in_ channel carries one stream byte per beat with its end_of_data and
// stream_start marks; the out_ channel returns one beat per input beat: the
// byte itself, its kind (header, payload or error) and an error code.
// A beat is taken on a rising edge where valid is high and stall is low.
// An accepted byte is held in the input register, is classified by
// the step logic against the parser state, and is captured in the result
// register when the result stage can advance, which raises out_valid.
// Throughput is one byte per cycle while out_stall is low; the parser state (phase, counters,
// saved flags, held error) updates in the same cycle a byte is classified.
// While out_stall holds the result, one more byte may still be taken into
// the input register; after that in_stall rises until the result moves.
// Synchronous reset clears both valid bits and returns the parser to the
// first magic byte with no error held. A beat with stream_start set
// restarts the parser before that byte is judged.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gzip_header_parser_unit import gzhp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_data,
  input  logic       in_stream_start,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [1:0] out_byte_kind,
  output logic [2:0] out_error_code
);

  logic         s1_valid_r;
  logic [7:0]   s1_byte_r;
  logic         s1_eod_r;
  logic         s1_start_r;
  logic         out_valid_r;
  logic [7:0]   out_byte_r;
  beat_class_t  out_cls_r;
  parse_state_t state_r;
  parse_state_t state_nxt;
  beat_class_t  cls_nxt;
  logic         adv;
  logic         s1_load;

  assign adv = !out_valid_r || !out_stall;
  assign s1_load = !s1_valid_r || adv;
  assign in_stall = !s1_load;

  gzhp_step u_step (
    .cur          (state_r),
    .in_byte      (s1_byte_r),
    .end_of_data  (s1_eod_r),
    .stream_start (s1_start_r),
    .nxt          (state_nxt),
    .cls          (cls_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      state_r <= STATE_RESET;
    end else begin
      if (s1_load) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
        if (s1_valid_r) begin
          state_r <= state_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_byte_r <= in_byte;
      s1_eod_r <= in_end_of_data;
      s1_start_r <= in_stream_start;
    end
    if (adv && s1_valid_r) begin
      out_byte_r <= s1_byte_r;
      out_cls_r <= cls_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte = out_byte_r;
  assign out_byte_kind = out_cls_r.kind;
  assign out_error_code = out_cls_r.err;

  `GZHP_ASSERT_SAME(a_code_only_on_error, out_valid_r && out_cls_r.kind != KIND_ERROR,
    out_cls_r.err == ERR_NONE, "error code set on a non-error beat")
  `GZHP_ASSERT_SAME(a_error_phase_holds_code, state_r.phase == PH_ERROR,
    state_r.error_held != ERR_NONE, "error phase without a held code")
  `GZHP_ASSERT_SAME(a_kind_legal, out_valid_r, out_cls_r.kind <= KIND_ERROR, "illegal byte kind")
  `GZHP_ASSERT_NEXT(a_state_frozen_on_stall, out_valid_r && out_stall,
    state_r == $past(state_r), "parser state moved while result stalled")

endmodule

### sim/gzip_header_parser_unit_tb.sv
// Self-checking testbench for the gzip member header parser unit.
`timescale 1ns / 1ps
module gzip_header_parser_unit_tb;
  import gzhp_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic [1:0] kind;
    logic [2:0] err;
  } gz_beat_t;

  typedef struct {
    logic [7:0] flg;
    int         xlen;
    int         name_len;
    int         cmt_len;
    int         pay_len;
    int         eod_pos;
    int         stop_pos;
    int         bad_pos;
    logic [7:0] bad_val;
  } member_plan_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'd0;
  logic       in_end_of_data = 1'b0;
  logic       in_stream_start = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] out_byte_kind;
  logic [2:0] out_error_code;

  gz_beat_t expected_beats[$];
  int       mismatch_count = 0;
  int       beats_sent = 0;
  int       members_sent = 0;
  int       header_seen = 0;
  int       payload_seen = 0;
  int       error_seen = 0;
  int       hold_cycles_req = 0;
  bit       idle_enable = 1'b1;

  logic [3:0]  gz_phase;
  logic [3:0]  gz_fixed_pos;
  logic [7:0]  gz_flags;
  logic [15:0] gz_skip;
  logic [7:0]  gz_xlen_lo;
  logic [2:0]  gz_held_err;

  gzip_header_parser_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_end_of_data  (in_end_of_data),
    .in_stream_start (in_stream_start),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_byte_kind   (out_byte_kind),
    .out_error_code  (out_error_code)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic void clear_parser();
    gz_phase = PH_FIXED;
    gz_fixed_pos = 4'd0;
    gz_flags = 8'd0;
    gz_skip = 16'd0;
    gz_xlen_lo = 8'd0;
    gz_held_err = ERR_NONE;
  endfunction

  function automatic logic [3:0] section_after(input logic [3:0] done);
    if (done < PH_XLEN_LO && (gz_flags & FLG_EXTRA) != 8'd0) return PH_XLEN_LO;
    if (done < PH_NAME && (gz_flags & FLG_NAME) != 8'd0) return PH_NAME;
    if (done < PH_COMMENT && (gz_flags & FLG_COMMENT) != 8'd0) return PH_COMMENT;
    if (done < PH_HCRC && (gz_flags & FLG_HCRC) != 8'd0) begin
      gz_skip = HCRC_LEN;
      return PH_HCRC;
    end
    return PH_PAYLOAD;
  endfunction

  function automatic gz_beat_t classify_byte(input logic [7:0] b, input logic eod,
                                             input logic start);
    gz_beat_t r;
    r.data = b;
    r.kind = KIND_HEADER;
    r.err = ERR_NONE;
    if (start) clear_parser();
    if (gz_phase == PH_ERROR) begin
      r.kind = KIND_ERROR;
      r.err = gz_held_err;
    end else if (gz_phase == PH_PAYLOAD) begin
      r.kind = KIND_PAYLOAD;
    end else begin
      case (gz_phase)
        PH_FIXED: begin
          if (gz_fixed_pos == IDX_ID1 && b != MAGIC_ID1) r.err = ERR_MAGIC;
          else if (gz_fixed_pos == IDX_ID2 && b != MAGIC_ID2) r.err = ERR_MAGIC;
          else if (gz_fixed_pos == IDX_METHOD && b != METHOD_DEFL) r.err = ERR_METHOD;
          else if (gz_fixed_pos == IDX_FLAGS) begin
            if ((b & FLG_RESERVED) != 8'd0) r.err = ERR_RESERVED;
            else gz_flags = b;
          end
          if (r.err == ERR_NONE) begin
            if (gz_fixed_pos >= FIXED_LAST) begin
              gz_fixed_pos = 4'd0;
              gz_phase = section_after(PH_FIXED);
            end else begin
              gz_fixed_pos = gz_fixed_pos + 4'd1;
            end
          end
        end
        PH_XLEN_LO: begin
          gz_xlen_lo = b;
          gz_phase = PH_XLEN_HI;
        end
        PH_XLEN_HI: begin
          gz_skip = {b, gz_xlen_lo};
          gz_phase = (gz_skip == 16'd0) ? section_after(PH_XDATA) : PH_XDATA;
        end
        PH_XDATA: begin
          gz_skip = gz_skip - 16'd1;
          if (gz_skip == 16'd0) gz_phase = section_after(PH_XDATA);
        end
        PH_NAME: begin
          if (b == 8'd0) gz_phase = section_after(PH_NAME);
        end
        PH_COMMENT: begin
          if (b == 8'd0) gz_phase = section_after(PH_COMMENT);
        end
        PH_HCRC: begin
          gz_skip = gz_skip - 16'd1;
          if (gz_skip == 16'd0) gz_phase = PH_PAYLOAD;
        end
        default: r.err = gz_held_err;
      endcase
      if (r.err == ERR_NONE && eod && gz_phase != PH_PAYLOAD) r.err = ERR_TRUNCATED;
      if (r.err != ERR_NONE) begin
        r.kind = KIND_ERROR;
        gz_held_err = r.err;
        gz_phase = PH_ERROR;
      end
    end
    if (r.kind != KIND_ERROR) r.err = ERR_NONE;
    return r;
  endfunction

  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eod, input logic start);
    gz_beat_t exp_beat;
    if (idle_enable && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      repeat (pick_idle_len()) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_end_of_data <= eod;
    in_stream_start <= start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    exp_beat = classify_byte(b, eod, start);
    expected_beats.push_back(exp_beat);
    beats_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
  endtask

  function automatic int header_length(input member_plan_t p);
    int n;
    n = 10;
    if ((p.flg & FLG_EXTRA) != 8'd0) n += 2 + p.xlen;
    if ((p.flg & FLG_NAME) != 8'd0) n += p.name_len + 1;
    if ((p.flg & FLG_COMMENT) != 8'd0) n += p.cmt_len + 1;
    if ((p.flg & FLG_HCRC) != 8'd0) n += 2;
    return n;
  endfunction

  function automatic member_plan_t plain_plan(input logic [7:0] flg);
    member_plan_t p;
    p.flg = flg;
    p.xlen = 0;
    p.name_len = 0;
    p.cmt_len = 0;
    p.pay_len = 0;
    p.eod_pos = -1;
    p.stop_pos = -1;
    p.bad_pos = -1;
    p.bad_val = 8'd0;
    return p;
  endfunction

  task automatic send_member(input member_plan_t p);
    logic [7:0]  q[$];
    logic [15:0] xl;
    xl = p.xlen[15:0];
    q = {MAGIC_ID1, MAGIC_ID2, METHOD_DEFL, p.flg};
    repeat (6) q.push_back(8'($urandom));
    if ((p.flg & FLG_EXTRA) != 8'd0) begin
      q.push_back(xl[7:0]);
      q.push_back(xl[15:8]);
      repeat (p.xlen) q.push_back(8'($urandom));
    end
    if ((p.flg & FLG_NAME) != 8'd0) begin
      repeat (p.name_len) q.push_back(8'($urandom_range(1, 255)));
      q.push_back(8'd0);
    end
    if ((p.flg & FLG_COMMENT) != 8'd0) begin
      repeat (p.cmt_len) q.push_back(8'($urandom_range(1, 255)));
      q.push_back(8'd0);
    end
    if ((p.flg & FLG_HCRC) != 8'd0) repeat (2) q.push_back(8'($urandom));
    repeat (p.pay_len) q.push_back(8'($urandom));
    if (p.bad_pos >= 0 && p.bad_pos < q.size()) q[p.bad_pos] = p.bad_val;
    for (int i = 0; i < q.size(); i++) begin
      if (p.stop_pos >= 0 && i > p.stop_pos) break;
      send_byte(q[i], i == p.eod_pos, i == 0);
    end
    members_sent++;
  endtask

  function automatic member_plan_t random_plan();
    member_plan_t p;
    int hl;
    int r;
    p = plain_plan(8'($urandom_range(0, 31)));
    p.xlen = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 6) : $urandom_range(7, 40);
    p.name_len = $urandom_range(0, 5);
    p.cmt_len = $urandom_range(0, 5);
    p.pay_len = $urandom_range(0, 8);
    hl = header_length(p);
    r = $urandom_range(0, 99);
    if (r < 50) begin
      p.eod_pos = hl + p.pay_len - 1;
    end else if (r < 65) begin
      p.eod_pos = -1;
    end else if (r < 80) begin
      p.eod_pos = $urandom_range(0, hl - 1);
      p.stop_pos = p.eod_pos + $urandom_range(0, 3);
    end else if (r < 95) begin
      p.bad_pos = $urandom_range(0, 3);
      p.bad_val = 8'($urandom);
      if (p.bad_pos == 3) p.bad_val = p.bad_val | (8'($urandom_range(1, 7)) << 5);
      p.stop_pos = p.bad_pos + $urandom_range(0, 4);
      if ($urandom_range(0, 3) == 0) p.eod_pos = p.bad_pos;
    end else begin
      p.eod_pos = $urandom_range(0, hl + p.pay_len);
    end
    return p;
  endfunction

  always @(posedge clk) begin : check_results
    gz_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        report_mismatch($sformatf("result beat with byte %02h but none expected", out_byte));
      end else begin
        want = expected_beats.pop_front();
        if (out_byte !== want.data)
          report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, want.data));
        if (out_byte_kind !== want.kind)
          report_mismatch($sformatf("byte %02h: byte_kind %0d, expected %0d",
                                    want.data, out_byte_kind, want.kind));
        if (out_error_code !== want.err)
          report_mismatch($sformatf("byte %02h: error_code %0d, expected %0d",
                                    want.data, out_error_code, want.err));
        case (want.kind)
          KIND_HEADER:  header_seen++;
          KIND_PAYLOAD: payload_seen++;
          default:      error_seen++;
        endcase
      end
    end
  end

  initial begin : drive_out_stall
    int n;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_cycles_req != 0) begin
        n = hold_cycles_req;
        hold_cycles_req = 0;
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!idle_enable || $urandom_range(0, 99) >= 25) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        repeat (pick_idle_len() - 1) @(posedge clk);
      end
    end
  end

  task automatic test_good_header();
    member_plan_t p;
    p = plain_plan(FLG_EXTRA | FLG_NAME | FLG_COMMENT | FLG_HCRC | 8'h01);
    p.name_len = 1;
    p.pay_len = 2;
    p.eod_pos = header_length(p) - 1;
    send_member(p);
    drain_results();
  endtask

  task automatic test_header_errors();
    member_plan_t p;
    send_byte(8'hFF, 1'b1, 1'b1);
    send_byte(8'h00, 1'b0, 1'b0);
    p = plain_plan(8'd0);
    p.bad_pos = 1;
    p.bad_val = 8'h8A;
    p.stop_pos = 1;
    send_member(p);
    p.bad_pos = 2;
    p.bad_val = 8'h07;
    p.stop_pos = 2;
    send_member(p);
    p.bad_pos = 3;
    p.bad_val = FLG_RESERVED;
    p.stop_pos = 3;
    send_member(p);
    send_byte(MAGIC_ID1, 1'b1, 1'b1);
    drain_results();
  endtask

  task automatic test_long_extra();
    member_plan_t p;
    p = plain_plan(FLG_EXTRA | FLG_HCRC);
    p.xlen = 300;
    p.pay_len = 3;
    p.eod_pos = header_length(p) + 2;
    send_member(p);
    p = plain_plan(FLG_EXTRA);
    p.xlen = 16'hFFFF;
    p.eod_pos = 17;
    p.stop_pos = 19;
    send_member(p);
    drain_results();
  endtask

  task automatic test_backpressure();
    idle_enable = 1'b0;
    hold_cycles_req = 40;
    repeat (3) send_member(random_plan());
    drain_results();
    idle_enable = 1'b1;
  endtask

  task automatic test_random_streams();
    int target;
    target = beats_sent + 1300;
    while (beats_sent < target) begin
      idle_enable = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 99) < 5) hold_cycles_req = $urandom_range(20, 80);
      if ($urandom_range(0, 99) < 6) begin
        repeat ($urandom_range(1, 8))
          send_byte(8'($urandom), $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
      end else begin
        send_member(random_plan());
      end
    end
    idle_enable = 1'b1;
  endtask

  initial begin
    clear_parser();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_good_header();
    test_header_errors();
    test_long_extra();
    test_backpressure();
    test_random_streams();
    drain_results();
    repeat (8) @(posedge clk);
    $display("Covered %0d stream bytes over %0d gzip members plus noise bursts,",
             beats_sent, members_sent);
    $display("with %0d header, %0d payload and %0d error results checked.",
             header_seen, payload_seen, error_seen);
    if (mismatch_count == 0 && expected_beats.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Timeout with %0d results still outstanding.", expected_beats.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/gzhp_pkg.sv
sv/gzhp_step.sv
sv/gzip_header_parser_unit.sv
sim/gzip_header_parser_unit_tb.sv
